[rtl/txf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txf_pkg
// Source format codes, widening helpers and defaults for the texel converter.
// ----------------------------------------------------------------------------
package txf_pkg;

  localparam int PAL_DEPTH_DEF = 256;

  localparam logic [3:0] FMT_RGBA16 = 4'd0;
  localparam logic [3:0] FMT_RGBA32 = 4'd1;
  localparam logic [3:0] FMT_IA4    = 4'd2;
  localparam logic [3:0] FMT_IA8    = 4'd3;
  localparam logic [3:0] FMT_IA16   = 4'd4;
  localparam logic [3:0] FMT_CI4    = 4'd5;
  localparam logic [3:0] FMT_CI8    = 4'd6;
  localparam logic [3:0] FMT_I4     = 4'd7;
  localparam logic [3:0] FMT_I8     = 4'd8;

  typedef logic [31:0][7:0] w5_tbl_t;

  // 5-bit to 8-bit widening table, x*255/31 truncated, built at elaboration.
  function automatic w5_tbl_t mk_w5_tbl();
    w5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  localparam w5_tbl_t W5_TBL = mk_w5_tbl();

  function automatic logic [7:0] widen4(input logic [3:0] x);
    return {x, x};
  endfunction

  function automatic logic [7:0] widen3(input logic [2:0] x);
    return {x, x, 2'b00};
  endfunction

endpackage

[rtl/texel_format_to_rgba32.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_rgba32
// Converts packed texels in nine source formats to RGBA8888 texels, with a
// palette store for the color-index formats.
// ----------------------------------------------------------------------------
// An accepted item is held in the conversion stage and each texel is then registered.
// Throughput: one item per cycle for one-texel formats while out_ready holds; a 4-bit
// item is held until the one-texel-per-cycle result register takes its second texel.
// Reset: source format returns to rgba16 and every palette entry reads as zero
// until written (per-entry valid bits, no clearing pass).
module texel_format_to_rgba32 #(
  parameter int PALETTE_DEPTH = txf_pkg::PAL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_data_word,
  input  logic [7:0]  in_palette_index,
  input  logic [15:0] in_palette_value,
  input  logic        in_last_word,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last_of_run,
  output logic        out_end_of_texture
);
  import txf_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  // Configuration.
  logic [3:0] fmt_r;

  // Palette store and its valid bits.
  logic [15:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_r;

  // Conversion stage.
  logic        a_vld_r;
  logic        a_vld_nxt;
  logic        ph_r;
  logic        ph_nxt;
  logic [31:0] a_word_r;
  logic        a_last_r;
  logic [15:0] rd0_r;
  logic [15:0] rd1_r;
  logic        ok0_r;
  logic        ok1_r;

  // Result register.
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  alpha_r;
  logic        lor_r;
  logic        eot_r;

  logic        out_load;
  logic        a_adv;
  logic        a_done;
  logic        in_acc;
  logic        keep;
  logic        wr_hit;
  logic [7:0]  addr0_full;
  logic [7:0]  addr1_full;
  logic        hit0;
  logic        hit1;

  logic [7:0]  byte_v;
  logic [3:0]  nib;
  logic [15:0] entry;
  logic        two;
  logic        last_tx;
  logic [7:0]  tx_r;
  logic [7:0]  tx_g;
  logic [7:0]  tx_b;
  logic [7:0]  tx_a;

  // Handshake control.
  assign cfg_ready = 1'b1;
  assign out_load  = !out_vld_r || out_ready;
  assign a_adv     = a_vld_r && out_load;
  assign a_done    = a_adv && last_tx;
  assign in_ready  = !a_vld_r || a_done;
  assign in_acc    = in_valid && in_ready;
  // Palette writes and items of an unknown format leave nothing to convert.
  assign keep      = in_acc && !in_op && (fmt_r <= FMT_I8);

  assign wr_hit     = {1'b0, in_palette_index} < DEPTH9;
  assign addr0_full = (fmt_r == FMT_CI8) ? in_data_word[7:0] : {4'h0, in_data_word[7:4]};
  assign addr1_full = {4'h0, in_data_word[3:0]};
  assign hit0       = {1'b0, addr0_full} < DEPTH9;
  assign hit1       = {1'b0, addr1_full} < DEPTH9;

  always_comb begin
    a_vld_nxt = a_vld_r;
    ph_nxt    = ph_r;
    if (in_acc) begin
      a_vld_nxt = keep;
      ph_nxt    = 1'b0;
    end else if (a_done) begin
      a_vld_nxt = 1'b0;
      ph_nxt    = 1'b0;
    end else if (a_adv) begin
      ph_nxt = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (a_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_RGBA16;
      pal_vld_r <= '0;
      a_vld_r   <= 1'b0;
      ph_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fmt_r <= cfg_data;
      end
      if (in_acc && in_op && wr_hit) begin
        pal_vld_r[in_palette_index[AW-1:0]] <= 1'b1;
      end
      a_vld_r   <= a_vld_nxt;
      ph_r      <= ph_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Palette memory: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (in_acc && in_op && wr_hit) begin
      pal_mem[in_palette_index[AW-1:0]] <= in_palette_value;
    end
    if (keep) begin
      rd0_r <= pal_mem[addr0_full[AW-1:0]];
      rd1_r <= pal_mem[addr1_full[AW-1:0]];
      ok0_r <= hit0 && pal_vld_r[addr0_full[AW-1:0]];
      ok1_r <= hit1 && pal_vld_r[addr1_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      a_word_r <= in_data_word;
      a_last_r <= in_last_word;
    end
  end

  // Texel conversion. The 4-bit formats take the high nibble first.
  assign byte_v = a_word_r[7:0];
  assign nib    = ph_r ? byte_v[3:0] : byte_v[7:4];
  assign entry  = ph_r ? (ok1_r ? rd1_r : 16'h0000) : (ok0_r ? rd0_r : 16'h0000);
  assign two    = fmt_r inside {FMT_IA4, FMT_CI4, FMT_I4};
  assign last_tx = !two || ph_r;

  always_comb begin
    tx_r = 8'h00;
    tx_g = 8'h00;
    tx_b = 8'h00;
    tx_a = 8'h00;
    case (fmt_r)
      FMT_RGBA16: begin
        tx_r = W5_TBL[a_word_r[15:11]];
        tx_g = W5_TBL[a_word_r[10:6]];
        tx_b = W5_TBL[a_word_r[5:1]];
        tx_a = {8{a_word_r[0]}};
      end
      FMT_RGBA32: begin
        tx_r = a_word_r[31:24];
        tx_g = a_word_r[23:16];
        tx_b = a_word_r[15:8];
        tx_a = a_word_r[7:0];
      end
      FMT_IA4: begin
        tx_r = widen3(nib[3:1]);
        tx_g = widen3(nib[3:1]);
        tx_b = widen3(nib[3:1]);
        tx_a = {8{nib[0]}};
      end
      FMT_IA8: begin
        tx_r = widen4(byte_v[7:4]);
        tx_g = widen4(byte_v[7:4]);
        tx_b = widen4(byte_v[7:4]);
        tx_a = widen4(byte_v[3:0]);
      end
      FMT_IA16: begin
        tx_r = a_word_r[15:8];
        tx_g = a_word_r[15:8];
        tx_b = a_word_r[15:8];
        tx_a = a_word_r[7:0];
      end
      FMT_CI4, FMT_CI8: begin
        tx_r = W5_TBL[entry[15:11]];
        tx_g = W5_TBL[entry[10:6]];
        tx_b = W5_TBL[entry[5:1]];
        tx_a = {8{entry[0]}};
      end
      FMT_I4: begin
        tx_r = widen4(nib);
        tx_g = widen4(nib);
        tx_b = widen4(nib);
        tx_a = 8'hFF;
      end
      FMT_I8: begin
        tx_r = byte_v;
        tx_g = byte_v;
        tx_b = byte_v;
        tx_a = 8'hFF;
      end
      default: begin
        tx_r = 8'h00;
        tx_g = 8'h00;
        tx_b = 8'h00;
        tx_a = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      red_r   <= tx_r;
      green_r <= tx_g;
      blue_r  <= tx_b;
      alpha_r <= tx_a;
      lor_r   <= last_tx;
      eot_r   <= last_tx && a_last_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_alpha          = alpha_r;
  assign out_last_of_run    = lor_r;
  assign out_end_of_texture = eot_r;

endmodule
